>>> src/cub_pkg.sv
package cub_pkg;

    // map geometry
    localparam int MAP_CLUSTERS = 262144;
    localparam int WORD_BITS    = 64;
    localparam int MAP_WORDS    = (MAP_CLUSTERS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int CL_W         = $clog2(MAP_CLUSTERS + 1);

    // byte and cluster arithmetic widths
    localparam int OFF_W  = 33;
    localparam int SIZE_W = 34;
    localparam int SUM_W  = 34;
    localparam int BYTE_W = 36;
    localparam int CLX_W  = 22;

    localparam int CLUSTER_SHIFT = 15;
    localparam logic [BYTE_W-1:0] CLUSTER_BYTES = BYTE_W'(32'h8000);
    localparam logic [BYTE_W-1:0] CLUSTER_ROUND = BYTE_W'(32'h7fff);

    // hashed data area is 0x7c00 = 31 << 10 bytes; divide by 31 via reciprocal
    localparam int DIV_SHIFT   = 10;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 29;
    localparam logic [RECIP_W-1:0] RECIP = 25'd17318417;
    localparam int QUO_W       = 20;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DISC_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HASHED_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCRUB_ENABLE = 2'd2;

    // operation codes
    localparam logic OP_MARK  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic            is_query;
        logic            hit;
        logic [CL_W-1:0] lo;
        logic [CL_W-1:0] hi;
    } cub_cmd_t;

    typedef struct packed {
        logic we;
        logic is_free;
        logic was_query;
    } cub_res_t;

endpackage

>>> src/cluster_usage_bitmap_core.sv
// Cluster free map, one bit per 32 KiB cluster, kept in a 64-bit wide RAM.
// After reset a clearing pass writes every map word (4096 here) to all free,
// during which full stays high; configuration writes are taken at any time
// (cfg_ready is always high). A front sequencer takes one word at a time
// through its sum, multiply, byte, cluster and push states, holding in push
// while the command queue is full, translates the byte range into a clamped
// cluster range and queues it; the back end works one queued command at a
// time through the single map RAM port pair: a query reads one map word
// (none when it falls beyond the disc), a mark reads, then writes, each
// 64-cluster map word it touches. Every word pushed yields exactly one
// result word in order; was_query tells a query answer from a finished mark.
module cluster_usage_bitmap_core import cub_pkg::*;
    (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 op,
    input  logic [OFF_W-1:0]     partition_base,
    input  logic [OFF_W-1:0]     offset,
    input  logic [OFF_W-1:0]     length,
    output logic                 empty,
    input  logic                 pop,
    output logic                 is_free,
    output logic                 was_query,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data
    );

    logic [CL_W-1:0]  lim_reg;
    logic             hashed_reg;
    logic             scrub_reg;
    logic             out_valid_reg;
    logic             out_free_reg;
    logic             out_query_reg;

    logic [SIZE_W:0]  disc_sum;
    logic [CL_W:0]    disc_cl;
    logic [CL_W-1:0]  lim_next;
    logic             front_busy;
    logic             clearing;
    logic             accept;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    cub_cmd_t         q_din;
    cub_cmd_t         q_dout;
    cub_res_t         res;
    logic             res_free;

    assign cfg_ready = 1'b1;
    assign full      = front_busy || clearing;
    assign accept    = push && !full;
    assign empty     = !out_valid_reg;
    assign is_free   = out_free_reg;
    assign was_query = out_query_reg;
    assign res_free  = !out_valid_reg || pop;

    // cluster limit: ceil(disc_size / cluster) clamped to the map size
    always_comb
    begin
        disc_sum = {1'b0, cfg_data} + (SIZE_W + 1)'(CLUSTER_ROUND);
        if ((disc_sum >> CLUSTER_SHIFT) < (SIZE_W + 1)'(MAP_CLUSTERS))
        begin
            disc_cl = (CL_W + 1)'(disc_sum >> CLUSTER_SHIFT);
        end
        else
        begin
            disc_cl = (CL_W + 1)'(MAP_CLUSTERS);
        end
        lim_next = CL_W'(disc_cl);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg    <= '0;
            hashed_reg <= 1'b0;
            scrub_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DISC_SIZE:    lim_reg    <= lim_next;
                REG_HASHED_MODE:  hashed_reg <= cfg_data[0];
                REG_SCRUB_ENABLE: scrub_reg  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // result output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.we)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.we)
        begin
            out_free_reg  <= res.is_free;
            out_query_reg <= res.was_query;
        end
    end

    cub_front u_front
        (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .op             (op),
        .partition_base (partition_base),
        .offset         (offset),
        .length         (length),
        .hashed_mode    (hashed_reg),
        .lim            (lim_reg),
        .busy           (front_busy),
        .q_push         (q_push),
        .q_full         (q_full),
        .cmd            (q_din)
        );

    cub_fifo u_queue
        (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
        );

    cub_back u_back
        (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_dout       (q_dout),
        .q_pop        (q_pop),
        .scrub_enable (scrub_reg),
        .res_free     (res_free),
        .res          (res),
        .clearing     (clearing)
        );

`ifndef ASSERT_OFF
    // no word taken while the map is being cleared
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> full)
        else $error("word accepted during clearing pass");

    // a result only lands in a free output slot
    a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res.we |-> (!out_valid_reg || pop))
        else $error("result overwrites a waiting result");

    // front never pushes into a full queue
    a_queue_push: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    // front is busy in the cycle after it takes a word
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> full)
        else $error("front ready right after accepting a word");
`endif

endmodule

>>> src/cub_ram.sv
module cub_ram
    #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
    )
    (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/cub_fifo.sv
module cub_fifo import cub_pkg::*;
    (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  cub_cmd_t din,
    output logic     full,
    input  logic     pop,
    output cub_cmd_t dout,
    output logic     empty
    );

    cub_cmd_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> src/cub_front.sv
module cub_front import cub_pkg::*;
    (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              op,
    input  logic [OFF_W-1:0]  partition_base,
    input  logic [OFF_W-1:0]  offset,
    input  logic [OFF_W-1:0]  length,
    input  logic              hashed_mode,
    input  logic [CL_W-1:0]   lim,
    output logic              busy,
    output logic              q_push,
    input  logic              q_full,
    output cub_cmd_t          cmd
    );

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_SUM  = 3'd1;
    localparam logic [2:0] F_MUL  = 3'd2;
    localparam logic [2:0] F_BYTE = 3'd3;
    localparam logic [2:0] F_CLU  = 3'd4;
    localparam logic [2:0] F_PUSH = 3'd5;

    localparam int P0_W = OFF_W - DIV_SHIFT + RECIP_W;
    localparam int P1_W = SUM_W - DIV_SHIFT + RECIP_W;

    logic [2:0]        state_reg, state_next;
    logic              op_reg;
    logic [OFF_W-1:0]  base_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [OFF_W-1:0]  len_reg;
    logic              len_nz_reg;
    logic [SUM_W-1:0]  end_raw_reg;
    logic [SUM_W-1:0]  last_reg;
    logic [QUO_W-1:0]  q0_reg;
    logic [QUO_W-1:0]  q1_reg;
    logic [BYTE_W-1:0] start_reg;
    logic [BYTE_W-1:0] end_reg;
    cub_cmd_t          cmd_reg;

    logic [P0_W-1:0]   p0;
    logic [P1_W-1:0]   p1;
    logic [BYTE_W-1:0] tc0;
    logic [BYTE_W-1:0] tc1;
    logic [BYTE_W-1:0] start_h;
    logic [BYTE_W-1:0] end_h;
    logic [BYTE_W-1:0] start_c;
    logic [BYTE_W-1:0] end_c;
    logic [BYTE_W:0]   hi_sum;
    logic [CLX_W-1:0]  lo_x;
    logic [CLX_W-1:0]  hi_x;
    logic [CLX_W-1:0]  lim_x;
    logic [CLX_W-1:0]  hi_c;
    logic [CLX_W-1:0]  lo_c;
    logic [CLX_W-1:0]  qc;
    cub_cmd_t          cmd_c;

    assign busy   = (state_reg != F_IDLE);
    assign q_push = (state_reg == F_PUSH) && !q_full;
    assign cmd    = cmd_reg;

    // divide by 31 through reciprocal, one product per offset
    assign p0 = P0_W'(off_reg[OFF_W-1:DIV_SHIFT]) * P0_W'(RECIP);
    assign p1 = P1_W'(last_reg[SUM_W-1:DIV_SHIFT]) * P1_W'(RECIP);

    // translate offsets to cluster aligned byte positions
    always_comb
    begin
        if (hashed_mode)
        begin
            tc0 = BYTE_W'(q0_reg) << CLUSTER_SHIFT;
            tc1 = BYTE_W'(q1_reg) << CLUSTER_SHIFT;
        end
        else
        begin
            tc0 = BYTE_W'(off_reg) & ~CLUSTER_ROUND;
            tc1 = BYTE_W'(last_reg) & ~CLUSTER_ROUND;
        end
        start_h = tc0 + BYTE_W'(base_reg);
        end_h   = tc1 + CLUSTER_BYTES + BYTE_W'(base_reg);
        if (base_reg == '0)
        begin
            start_c = BYTE_W'(off_reg);
            end_c   = BYTE_W'(end_raw_reg);
        end
        else
        begin
            start_c = start_h;
            end_c   = len_nz_reg ? end_h : start_h;
        end
    end

    // byte range to clamped cluster range
    always_comb
    begin
        hi_sum = {1'b0, end_reg} + {1'b0, CLUSTER_ROUND};
        lo_x   = CLX_W'(start_reg >> CLUSTER_SHIFT);
        hi_x   = CLX_W'(hi_sum >> CLUSTER_SHIFT);
        lim_x  = CLX_W'(lim);
        hi_c   = (hi_x < lim_x) ? hi_x : lim_x;
        lo_c   = (lo_x < hi_c) ? lo_x : hi_c;
        qc     = CLX_W'(off_reg >> CLUSTER_SHIFT);
        cmd_c.is_query = (op_reg == OP_QUERY);
        cmd_c.hit      = (qc < lim_x);
        cmd_c.lo       = (op_reg == OP_QUERY) ? CL_W'(qc) : CL_W'(lo_c);
        cmd_c.hi       = CL_W'(hi_c);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_SUM;
                end
            end
            F_SUM:   state_next = F_MUL;
            F_MUL:   state_next = F_BYTE;
            F_BYTE:  state_next = F_CLU;
            F_CLU:   state_next = F_PUSH;
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // payload registers per step
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && accept)
        begin
            op_reg   <= op;
            base_reg <= partition_base;
            off_reg  <= offset;
            len_reg  <= length;
        end
        if (state_reg == F_SUM)
        begin
            len_nz_reg  <= (len_reg != '0);
            end_raw_reg <= SUM_W'(off_reg) + SUM_W'(len_reg);
            last_reg    <= SUM_W'(off_reg) + SUM_W'(len_reg) - SUM_W'(1);
        end
        if (state_reg == F_MUL)
        begin
            q0_reg <= QUO_W'(p0 >> RECIP_SHIFT);
            q1_reg <= QUO_W'(p1 >> RECIP_SHIFT);
        end
        if (state_reg == F_BYTE)
        begin
            start_reg <= start_c;
            end_reg   <= end_c;
        end
        if (state_reg == F_CLU)
        begin
            cmd_reg <= cmd_c;
        end
    end

endmodule

>>> src/cub_back.sv
module cub_back import cub_pkg::*;
    (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_empty,
    input  cub_cmd_t q_dout,
    output logic     q_pop,
    input  logic     scrub_enable,
    input  logic     res_free,
    output cub_res_t res,
    output logic     clearing
    );

    localparam logic [1:0] B_CLR  = 2'd0;
    localparam logic [1:0] B_IDLE = 2'd1;
    localparam logic [1:0] B_RD   = 2'd2;
    localparam logic [1:0] B_WR   = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [CL_W-1:0]      cur_reg, cur_next;
    logic [CL_W-1:0]      hi_reg, hi_next;
    logic                 query_reg, query_next;

    logic [ADDR_W-1:0]    word;
    logic [CL_W:0]        wbase;
    logic [CL_W:0]        nxt;
    logic [CL_W:0]        pos;
    logic                 done;
    logic [WORD_BITS-1:0] clr_mask;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [WORD_BITS-1:0] ram_rdata;

    assign clearing = (state_reg == B_CLR);
    assign word     = ADDR_W'(cur_reg >> BIT_W);
    assign wbase    = (CL_W + 1)'(cur_reg >> BIT_W) << BIT_W;
    assign nxt      = wbase + ((CL_W + 1)'(1) << BIT_W);
    assign done     = (nxt >= {1'b0, hi_reg});

    // bits of the current word inside the range
    always_comb
    begin
        pos = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            pos         = wbase + (CL_W + 1)'(j);
            clr_mask[j] = (BIT_W'(j) >= cur_reg[BIT_W-1:0]) && (pos < {1'b0, hi_reg});
        end
    end

    // sequencer: clearing pass, command dispatch, read-modify-write walk
    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        cur_next      = cur_reg;
        hi_next       = hi_reg;
        query_next    = query_reg;
        q_pop         = 1'b0;
        res.we        = 1'b0;
        res.is_free   = 1'b0;
        res.was_query = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = word;
        ram_wdata     = ram_rdata & ~clr_mask;
        ram_re        = 1'b0;
        unique case (state_reg)
            B_CLR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '1;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(MAP_WORDS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty && res_free)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_dout.lo;
                    hi_next    = q_dout.hi;
                    query_next = q_dout.is_query;
                    if (q_dout.is_query)
                    begin
                        if (q_dout.hit)
                        begin
                            state_next = B_RD;
                        end
                        else
                        begin
                            res.we        = 1'b1;
                            res.was_query = 1'b1;
                        end
                    end
                    else if (q_dout.lo < q_dout.hi)
                    begin
                        state_next = B_RD;
                    end
                    else
                    begin
                        res.we = 1'b1;
                    end
                end
            end
            B_RD:
            begin
                ram_re     = 1'b1;
                state_next = B_WR;
            end
            B_WR:
            begin
                if (query_reg)
                begin
                    res.we        = 1'b1;
                    res.was_query = 1'b1;
                    res.is_free   = scrub_enable && ram_rdata[cur_reg[BIT_W-1:0]];
                    state_next    = B_IDLE;
                end
                else
                begin
                    ram_we = 1'b1;
                    if (done)
                    begin
                        res.we     = 1'b1;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        cur_next   = CL_W'(nxt);
                        state_next = B_RD;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_CLR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        hi_reg    <= hi_next;
        query_reg <= query_next;
    end

    // free map storage
    cub_ram
        #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
        )
    u_map
        (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (word),
        .rdata (ram_rdata)
        );

endmodule

>>> tb/cluster_map_checker.sv
`timescale 1ns / 100ps

module cluster_map_checker import cub_pkg::*;
    (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 full,
    input  logic                 op,
    input  logic [OFF_W-1:0]     partition_base,
    input  logic [OFF_W-1:0]     offset,
    input  logic [OFF_W-1:0]     length,
    input  logic                 empty,
    input  logic                 pop,
    input  logic                 is_free,
    input  logic                 was_query,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    output int                   mismatches,
    output int                   pending
    );

    localparam logic [63:0] CLUSTER_SPAN = 64'h8000;
    localparam logic [63:0] HASHED_SPAN  = 64'h7c00;
    localparam logic [63:0] MAP_LIMIT    = 64'(MAP_CLUSTERS);

    typedef struct packed {
        logic is_free;
        logic was_query;
    } answer_t;

    // shadow of the free map and the settings
    bit                free_bits [MAP_CLUSTERS];
    logic [SIZE_W-1:0] disc_bytes;
    logic              hashed_on;
    logic              scrub_on;
    answer_t           awaited_words [$];

    // byte offset inside a partition to the byte offset of its cluster
    function automatic logic [63:0] data_cluster_offset(input logic [63:0] bytes);
        if (hashed_on)
            return bytes / HASHED_SPAN * CLUSTER_SPAN;
        return bytes & ~(CLUSTER_SPAN - 64'd1);
    endfunction

    function automatic logic [63:0] round_up_clusters(input logic [63:0] bytes);
        return (bytes + CLUSTER_SPAN - 64'd1) >> CLUSTER_SHIFT;
    endfunction

    // clear clusters from the one holding first_byte up to end_byte, clamped
    function automatic void mark_used(input logic [63:0] first_byte,
                                      input logic [63:0] end_byte);
        logic [63:0] limit;
        logic [63:0] disc_clusters;
        limit = round_up_clusters(end_byte);
        disc_clusters = round_up_clusters(64'(disc_bytes));
        if (disc_clusters < limit)
            limit = disc_clusters;
        if (MAP_LIMIT < limit)
            limit = MAP_LIMIT;
        for (logic [63:0] c = first_byte >> CLUSTER_SHIFT; c < limit; c++)
            free_bits[c] = 1'b0;
    endfunction

    // apply one accepted word to the shadow map and return its answer
    function automatic answer_t predict_word(input logic kind,
                                             input logic [OFF_W-1:0] base,
                                             input logic [OFF_W-1:0] off,
                                             input logic [OFF_W-1:0] len);
        answer_t     ans;
        logic [63:0] c;
        logic [63:0] lo;
        logic [63:0] hi;
        ans = '0;
        if (kind == OP_QUERY)
        begin
            c = 64'(off) >> CLUSTER_SHIFT;
            ans.was_query = 1'b1;
            if (c < round_up_clusters(64'(disc_bytes)) && c < MAP_LIMIT)
                ans.is_free = scrub_on && free_bits[c];
        end
        else if (base == '0)
        begin
            mark_used(64'(off), 64'(off) + 64'(len));
        end
        else
        begin
            lo = data_cluster_offset(64'(off)) + 64'(base);
            hi = lo;
            if (len != '0)
                hi = data_cluster_offset(64'(off) + 64'(len) - 64'd1) + CLUSTER_SPAN
                     + 64'(base);
            mark_used(lo, hi);
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            foreach (free_bits[i])
                free_bits[i] = 1'b1;
            disc_bytes = '0;
            hashed_on = 1'b0;
            scrub_on = 1'b0;
            awaited_words.delete();
            mismatches = 0;
        end
        else
        begin
            // settings writes
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_DISC_SIZE:    disc_bytes = cfg_data;
                    REG_HASHED_MODE:  hashed_on = cfg_data[0];
                    REG_SCRUB_ENABLE: scrub_on = cfg_data[0];
                    default:          ;
                endcase
            end

            // result words against the oldest prediction
            if (pop && !empty)
            begin
                if (awaited_words.size() == 0)
                begin
                    $display("%0t: expected no result word, got is_free %0b was_query %0b",
                             $time, is_free, was_query);
                    mismatches++;
                end
                else
                begin
                    want = awaited_words.pop_front();
                    if (is_free !== want.is_free)
                    begin
                        $display("%0t: is_free mismatch, expected %0b, got %0b",
                                 $time, want.is_free, is_free);
                        mismatches++;
                    end
                    if (was_query !== want.was_query)
                    begin
                        $display("%0t: was_query mismatch, expected %0b, got %0b",
                                 $time, want.was_query, was_query);
                        mismatches++;
                    end
                end
            end

            // input words
            if (push && !full)
                awaited_words.push_back(predict_word(op, partition_base, offset, length));
        end
        pending <= awaited_words.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import cub_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 64;
    localparam int HOT_CLUSTERS   = 2048;
    localparam int PHASE_WORDS    = 62;
    localparam int PHASES         = 7;

    localparam logic [SIZE_W-1:0] DISC_FULL    = 34'h2_0000_0000;
    localparam logic [SIZE_W-1:0] DISC_CLUSTER = 34'h8000;
    localparam logic [OFF_W-1:0]  LAST_BYTE    = 33'h1_ffff_ffff;
    localparam logic [OFF_W-1:0]  STEP         = 33'h8000;
    localparam logic [OFF_W-1:0]  HASHED_STEP  = 33'h7c00;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic                 op;
    logic [OFF_W-1:0]     partition_base;
    logic [OFF_W-1:0]     offset;
    logic [OFF_W-1:0]     length;
    logic                 empty;
    logic                 pop;
    logic                 is_free;
    logic                 was_query;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;

    int                   mismatches;
    int                   pending;
    bit                   calm;
    int                   stall_odds;
    logic [OFF_W-1:0]     recent_off;
    logic [SIZE_W-1:0]    disc_pick;

    wire moved = (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    cluster_usage_bitmap_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .op             (op),
        .partition_base (partition_base),
        .offset         (offset),
        .length         (length),
        .empty          (empty),
        .pop            (pop),
        .is_free        (is_free),
        .was_query      (was_query),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    cluster_map_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .op             (op),
        .partition_base (partition_base),
        .offset         (offset),
        .length         (length),
        .empty          (empty),
        .pop            (pop),
        .is_free        (is_free),
        .was_query      (was_query),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    function automatic logic [OFF_W-1:0] any_offset();
        return {1'($urandom_range(0, 1)), $urandom};
    endfunction

    // present one word, with an optional gap first; push stays high afterwards
    task automatic send_word(input logic kind, input logic [OFF_W-1:0] base,
                             input logic [OFF_W-1:0] off, input logic [OFF_W-1:0] len);
        if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        push <= 1'b1;
        op <= kind;
        partition_base <= base;
        offset <= off;
        length <= len;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    // stop sending and wait for every outstanding result word
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // write all three settings back to back
    task automatic load_settings(input logic [SIZE_W-1:0] size, input logic hashed,
                                 input logic scrub);
        logic [CFG_IDX_W-1:0] reg_at [3];
        logic [SIZE_W-1:0]    value_at [3];
        reg_at = '{REG_DISC_SIZE, REG_HASHED_MODE, REG_SCRUB_ENABLE};
        value_at = '{size, SIZE_W'(hashed), SIZE_W'(scrub)};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_at[i];
            cfg_data <= value_at[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // random word, mostly small ranges and queries in a busy low window
    task automatic random_word();
        logic             kind;
        logic [OFF_W-1:0] base;
        logic [OFF_W-1:0] off;
        logic [OFF_W-1:0] len;
        int               pick;
        kind = ($urandom_range(0, 9) < 4) ? OP_QUERY : OP_MARK;

        pick = $urandom_range(0, 19);
        if (pick < 14)
            off = OFF_W'($urandom_range(0, HOT_CLUSTERS - 1)) * STEP
                  + OFF_W'($urandom_range(0, 32'h7fff));
        else if (pick < 18)
            off = recent_off + OFF_W'($urandom_range(0, 3)) * STEP - STEP;
        else
            off = any_offset();

        // huge lengths only near the top of the map so the map is not used up
        pick = $urandom_range(0, 19);
        if (pick < 2)
            len = '0;
        else if (pick < 15)
            len = OFF_W'($urandom_range(1, 3 * 32'h8000));
        else if (pick < 18)
            len = OFF_W'($urandom_range(1, 40 * 32'h8000));
        else begin
            len = any_offset();
            off = LAST_BYTE - OFF_W'($urandom_range(0, 32'h1f_ffff));
        end

        pick = $urandom_range(0, 19);
        if (pick < 8)
            base = '0;
        else if (pick < 17)
            base = OFF_W'($urandom_range(1, HOT_CLUSTERS * 32'h8000));
        else
            base = any_offset();

        if (kind == OP_MARK)
            recent_off = off;
        send_word(kind, base, off, len);
    endtask

    // result side, stalls in bursts
    initial
    begin
        pop <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else begin
                pop <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // watchdog on cycles without any handshake
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (moved)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("cluster_usage_bitmap_core regression: fail");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        push <= 1'b0;
        op <= OP_MARK;
        partition_base <= '0;
        offset <= '0;
        length <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_DISC_SIZE;
        cfg_data <= '0;
        calm = 1'b0;
        stall_odds = 4;
        recent_off = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // raw ranges, zero lengths, boundaries and the end of the map
        load_settings(DISC_FULL, 1'b0, 1'b1);
        send_word(OP_QUERY, '0, '0, '0);
        send_word(OP_MARK, '0, '0, '0);
        send_word(OP_QUERY, '0, '0, '0);
        send_word(OP_MARK, '0, 10 * STEP + 5, 33'd1);
        send_word(OP_QUERY, '0, 10 * STEP, '0);
        send_word(OP_QUERY, '0, 11 * STEP - 1, '0);
        send_word(OP_QUERY, '0, 11 * STEP, '0);
        send_word(OP_MARK, '0, 21 * STEP - 1, 33'd2);
        send_word(OP_QUERY, '0, 21 * STEP, '0);
        send_word(OP_MARK, 100 * STEP, '0, '0);
        send_word(OP_QUERY, '0, 100 * STEP, '0);
        send_word(OP_MARK, 100 * STEP, STEP, STEP);
        send_word(OP_QUERY, '0, 101 * STEP, '0);
        send_word(OP_MARK, '0, LAST_BYTE, LAST_BYTE);
        send_word(OP_QUERY, '0, LAST_BYTE, '0);
        send_word(OP_MARK, LAST_BYTE, LAST_BYTE, LAST_BYTE);

        // hashed translation
        drain();
        load_settings(DISC_FULL, 1'b1, 1'b1);
        send_word(OP_MARK, 200 * STEP, 3 * HASHED_STEP + 5, HASHED_STEP);
        send_word(OP_QUERY, '0, 204 * STEP, '0);
        send_word(OP_QUERY, '0, 205 * STEP, '0);

        // small disc: queries past its end and marks clamped to it
        drain();
        load_settings(50 * DISC_CLUSTER + 1, 1'b0, 1'b1);
        send_word(OP_QUERY, '0, 50 * STEP, '0);
        send_word(OP_QUERY, '0, 51 * STEP, '0);
        send_word(OP_MARK, '0, '0, LAST_BYTE);
        send_word(OP_QUERY, '0, 50 * STEP, '0);

        // scrubbing off hides free clusters
        drain();
        load_settings(DISC_FULL, 1'b0, 1'b0);
        send_word(OP_QUERY, '0, 60 * STEP, '0);

        // random phases under changing settings
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: disc_pick = DISC_FULL;
                1: disc_pick = '0;
                2: disc_pick = SIZE_W'($urandom_range(1, 3000 * 32'h8000));
                3: disc_pick = DISC_FULL - 1;
                4: disc_pick = SIZE_W'({$urandom_range(0, 1), $urandom});
                5: disc_pick = DISC_FULL;
                default: disc_pick = SIZE_W'($urandom_range(1, 3000 * 32'h8000));
            endcase
            load_settings(disc_pick, (ph == 3) ? 1'b0 : 1'($urandom_range(0, 1) | (ph % 2)),
                          ph != 3);
            stall_odds = (ph == 2) ? 0 : ((ph % 2 == 0) ? 3 : 8);
            calm = (ph == PHASES - 1);
            repeat (PHASE_WORDS) random_word();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("cluster_usage_bitmap_core regression: pass");
        else
            $display("cluster_usage_bitmap_core regression: fail");
        $finish;
    end

endmodule
